// ===== sv/gtg_pkg.sv =====
// Package for the go-to-goal velocity controller: widths, register indexes,
// scaling constants, CORDIC arctangent table and shared types. No dependencies.
package gtg_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_BITS_DEF    = 16;

   localparam int POS_W  = 32;
   localparam int HEAD_W = 16;
   localparam int CFG_W  = 24;
   localparam int IDX_W  = 3;
   localparam int ANG_W  = 32;
   // CORDIC datapath width: 33-bit difference plus growth from the rotations.
   localparam int CW     = 36;

   localparam logic [30:0] INV_K_Q30  = 31'd652032874;
   localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

   typedef enum logic [IDX_W-1:0] {
      REG_DIST_TOL = 3'd0,
      REG_ANG_TOL  = 3'd1,
      REG_LIN_GAIN = 3'd2,
      REG_ANG_GAIN = 3'd3,
      REG_LIN_MAX  = 3'd4,
      REG_ANG_MAX  = 3'd5,
      REG_LIN_MIN  = 3'd6,
      REG_ANG_MIN  = 3'd7
   } reg_idx_type;

   typedef enum logic [1:0] {
      MODE_FACE   = 2'd0,
      MODE_DRIVE  = 2'd1,
      MODE_ALIGN  = 2'd2,
      MODE_ARRIVE = 2'd3
   } mode_type;

   // Payload that travels down the CORDIC chain next to the vector.
   typedef struct packed {
      logic [ANG_W-1:0] th_t;
      logic [ANG_W-1:0] th_c;
   } side_type;

   function automatic logic [ANG_W-1:0] atan_bau(input logic [4:0] s);
      logic [ANG_W-1:0] r;
      case (s)
         5'd0:  r = 32'h20000000;  5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;  5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;  5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;  5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;  5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;  5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;  5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;  5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;  5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;  5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;  5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;  5'd23: r = 32'h00000051;
         5'd24: r = 32'h00000028;  5'd25: r = 32'h00000014;
         5'd26: r = 32'h0000000A;  5'd27: r = 32'h00000005;
         5'd28: r = 32'h00000002;  5'd29: r = 32'h00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/go_to_goal_velocity_controller_unit.sv =====
// Top level of the go-to-goal velocity controller.
// Depends on gtg_pkg, gtg_regs and gtg_cell.
//
// The block takes one pose pair per clock cycle unless the output stalls, and
// returns one velocity command per item. An item passes a prescale stage, a
// chain of CORDIC_STAGES vectoring cells, and six stages that scale the
// distance, turn the angle errors into radians, pick the mode, apply the gain
// and clamp. The whole pipe advances whenever the output register is empty
// or being taken, so a stalled output holds every stage. There is no
// clearing pass; commands follow reset at once.
module go_to_goal_velocity_controller_unit #(
   parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS    = gtg_pkg::ANGLE_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [gtg_pkg::POS_W-1:0]  req_target_x,
   input  logic signed [gtg_pkg::POS_W-1:0]  req_target_y,
   input  logic signed [gtg_pkg::HEAD_W-1:0] req_target_heading,
   input  logic signed [gtg_pkg::POS_W-1:0]  req_current_x,
   input  logic signed [gtg_pkg::POS_W-1:0]  req_current_y,
   input  logic signed [gtg_pkg::HEAD_W-1:0] req_current_heading,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [23:0]                       rsp_linear_velocity,
   output logic signed [24:0]                rsp_angular_velocity,
   output logic [1:0]                        rsp_control_mode,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [gtg_pkg::IDX_W-1:0]         csr_index,
   input  logic [gtg_pkg::CFG_W-1:0]         csr_data
);

   localparam int CW   = gtg_pkg::CW;
   localparam int AW   = gtg_pkg::ANG_W;
   localparam int MW   = ANGLE_BITS + 27;

   logic [23:0] dist_tol, ang_tol, lin_gain, ang_gain;
   logic [23:0] lin_max, ang_max, lin_min, ang_min;

   gtg_regs u_regs (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .dist_tol(dist_tol), .ang_tol(ang_tol),
      .lin_gain(lin_gain), .ang_gain(ang_gain),
      .lin_max(lin_max), .ang_max(ang_max),
      .lin_min(lin_min), .ang_min(ang_min)
   );

   // The whole pipe moves when the output register can take a result.
   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // Prescale stage: differences and reflection into the right half plane.
   logic signed [CW-1:0] dx, dy;
   logic                 p_v_ff;
   logic signed [CW-1:0] p_x_ff, p_y_ff;
   logic [AW-1:0]        p_z_ff;
   gtg_pkg::side_type    p_s_ff;

   assign dx = CW'(req_target_x) - CW'(req_current_x);
   assign dy = CW'(req_target_y) - CW'(req_current_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (adv) begin
         p_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_x_ff <= (dx < 0) ? -dx : dx;
         p_y_ff <= (dx < 0) ? -dy : dy;
         p_z_ff <= (dx < 0) ? 32'h80000000 : '0;
         p_s_ff.th_t <= {req_target_heading, 16'h0000};
         p_s_ff.th_c <= {req_current_heading, 16'h0000};
      end
   end

   // Chain of vectoring cells.
   logic                 c_v [CORDIC_STAGES+1];
   logic signed [CW-1:0] c_x [CORDIC_STAGES+1];
   logic signed [CW-1:0] c_y [CORDIC_STAGES+1];
   logic [AW-1:0]        c_z [CORDIC_STAGES+1];
   gtg_pkg::side_type    c_s [CORDIC_STAGES+1];

   assign c_v[0] = p_v_ff;
   assign c_x[0] = p_x_ff;
   assign c_y[0] = p_y_ff;
   assign c_z[0] = p_z_ff;
   assign c_s[0] = p_s_ff;

   for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
      gtg_cell #(.STAGE(g)) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .v_in(c_v[g]), .x_in(c_x[g]), .y_in(c_y[g]), .z_in(c_z[g]), .s_in(c_s[g]),
         .v_out(c_v[g+1]), .x_out(c_x[g+1]), .y_out(c_y[g+1]),
         .z_out(c_z[g+1]), .s_out(c_s[g+1])
      );
   end

   // Stage A: scale magnitude by 1/K, form wrapped errors and their magnitudes.
   logic [AW-1:0]         eb, eh;
   logic [AW:0]           mb, mh;
   logic                  a_v_ff, a_nb_ff, a_nh_ff;
   logic [CW+30:0]        a_rho_ff;
   logic [ANGLE_BITS-1:0] a_mb_ff, a_mh_ff;

   assign eb = c_z[CORDIC_STAGES] - c_s[CORDIC_STAGES].th_c;
   assign eh = c_s[CORDIC_STAGES].th_t - c_s[CORDIC_STAGES].th_c;
   assign mb = eb[AW-1] ? (33'h100000000 - {1'b0, eb}) : {1'b0, eb};
   assign mh = eh[AW-1] ? (33'h100000000 - {1'b0, eh}) : {1'b0, eh};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= c_v[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_rho_ff <= (CW+31)'(unsigned'(c_x[CORDIC_STAGES])) * (CW+31)'(gtg_pkg::INV_K_Q30);
         a_nb_ff  <= eb[AW-1];
         a_nh_ff  <= eh[AW-1];
         a_mb_ff  <= mb[AW:AW+1-ANGLE_BITS] == '0 ? ANGLE_BITS'(mb >> (AW - ANGLE_BITS))
                                                  : ANGLE_BITS'(mb >> (AW - ANGLE_BITS));
         a_mh_ff  <= ANGLE_BITS'(mh >> (AW - ANGLE_BITS));
      end
   end

   // Stage B: convert the error magnitudes to Q3.40 radians (Q3.16 after stage C's shift).
   logic        b_v_ff, b_nb_ff, b_nh_ff;
   logic [36:0] b_rho_ff;
   logic [MW-1:0] b_rb_ff, b_rh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (adv) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_rho_ff <= 37'(a_rho_ff >> 30);
         b_nb_ff  <= a_nb_ff;
         b_nh_ff  <= a_nh_ff;
         b_rb_ff  <= MW'(a_mb_ff) * MW'(gtg_pkg::TWO_PI_Q24);
         b_rh_ff  <= MW'(a_mh_ff) * MW'(gtg_pkg::TWO_PI_Q24);
      end
   end

   // Stage C: pick the mode and the magnitude that the gain applies to.
   logic [MW-1:0] rad_b, rad_h;
   logic          far, bfar, hfar;
   logic          c_v_ff, c_neg_ff;
   logic [1:0]    c_mode_ff;
   logic [36:0]   c_mag_ff;

   assign rad_b = b_rb_ff >> (ANGLE_BITS + 8);
   assign rad_h = b_rh_ff >> (ANGLE_BITS + 8);
   assign far   = b_rho_ff > 37'(dist_tol);
   assign bfar  = rad_b > MW'(ang_tol);
   assign hfar  = rad_h > MW'(ang_tol);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (adv) begin
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (far && bfar) begin
            c_mode_ff <= gtg_pkg::MODE_FACE;
            c_mag_ff  <= 37'(rad_b);
            c_neg_ff  <= b_nb_ff;
         end else if (far) begin
            c_mode_ff <= gtg_pkg::MODE_DRIVE;
            c_mag_ff  <= b_rho_ff;
            c_neg_ff  <= 1'b0;
         end else if (hfar) begin
            c_mode_ff <= gtg_pkg::MODE_ALIGN;
            c_mag_ff  <= 37'(rad_h);
            c_neg_ff  <= b_nh_ff;
         end else begin
            c_mode_ff <= gtg_pkg::MODE_ARRIVE;
            c_mag_ff  <= '0;
            c_neg_ff  <= 1'b0;
         end
      end
   end

   // Stage D: gain times magnitude (product kept whole, shifted later).
   logic        d_v_ff, d_neg_ff;
   logic [1:0]  d_mode_ff;
   logic [60:0] d_prod_ff;
   logic [23:0] gain;

   assign gain = (c_mode_ff == gtg_pkg::MODE_DRIVE) ? lin_gain : ang_gain;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (adv) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_mode_ff <= c_mode_ff;
         d_neg_ff  <= c_neg_ff;
         d_prod_ff <= 61'(gain) * 61'(c_mag_ff);
      end
   end

   // Stage E: clamp to the maximum, then raise to the minimum; arrive mode gives zero.
   logic [44:0] cmd;
   logic [23:0] mx, mn, clamped;
   logic        e_v_ff, e_neg_ff;
   logic [1:0]  e_mode_ff;
   logic [23:0] e_mag_ff;

   assign cmd = 45'(d_prod_ff >> 16);
   assign mx  = (d_mode_ff == gtg_pkg::MODE_DRIVE) ? lin_max : ang_max;
   assign mn  = (d_mode_ff == gtg_pkg::MODE_DRIVE) ? lin_min : ang_min;

   always_comb begin
      clamped = (cmd > 45'(mx)) ? mx : cmd[23:0];
      if (clamped < mn) begin
         clamped = mn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (adv) begin
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_mode_ff <= d_mode_ff;
         e_neg_ff  <= d_neg_ff;
         e_mag_ff  <= (d_mode_ff == gtg_pkg::MODE_ARRIVE) ? '0 : clamped;
      end
   end

   // Output register: place the command on the right field with its sign.
   logic        rsp_valid_ff;
   logic [23:0] lin_ff;
   logic [24:0] ang_ff;
   logic [1:0]  mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= e_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mode_ff <= e_mode_ff;
         if (e_mode_ff == gtg_pkg::MODE_DRIVE) begin
            lin_ff <= e_mag_ff;
            ang_ff <= '0;
         end else begin
            lin_ff <= '0;
            ang_ff <= e_neg_ff ? (25'd0 - {1'b0, e_mag_ff}) : {1'b0, e_mag_ff};
         end
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_linear_velocity  = lin_ff;
   assign rsp_angular_velocity = ang_ff;
   assign rsp_control_mode     = mode_ff;

   // Checks on the pipeline and result encoding.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angular_velocity))
      else $error("result changed while stalled");
   a_drive_no_turn: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_control_mode == gtg_pkg::MODE_DRIVE |-> rsp_angular_velocity == '0)
      else $error("turn rate in drive mode");
   a_turn_no_speed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_control_mode != gtg_pkg::MODE_DRIVE |-> rsp_linear_velocity == '0)
      else $error("speed outside drive mode");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

endmodule

// ===== sv/gtg_cell.sv =====
// One CORDIC vectoring cell: a single micro-rotation and its pipeline register.
// Depends on gtg_pkg.
module gtg_cell #(
   parameter int STAGE = 0
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        v_in,
   input  logic signed [gtg_pkg::CW-1:0] x_in,
   input  logic signed [gtg_pkg::CW-1:0] y_in,
   input  logic [gtg_pkg::ANG_W-1:0]   z_in,
   input  gtg_pkg::side_type           s_in,
   output logic                        v_out,
   output logic signed [gtg_pkg::CW-1:0] x_out,
   output logic signed [gtg_pkg::CW-1:0] y_out,
   output logic [gtg_pkg::ANG_W-1:0]   z_out,
   output gtg_pkg::side_type           s_out
);

   localparam int SH = STAGE % 32;
   localparam logic [4:0] SIDX = 5'(SH);

   logic signed [gtg_pkg::CW-1:0] xs, ys, x_in_c, y_in_c;
   logic [gtg_pkg::ANG_W-1:0]     z_in_c, at;
   logic                          v_ff;
   logic signed [gtg_pkg::CW-1:0] x_ff, y_ff;
   logic [gtg_pkg::ANG_W-1:0]     z_ff;
   gtg_pkg::side_type             s_ff;

   // Arithmetic shifts floor negative values, as the rotation needs.
   assign xs = x_in >>> SH;
   assign ys = y_in >>> SH;
   assign at = gtg_pkg::atan_bau(SIDX);

   // Rotate toward the x axis by the sign of y.
   always_comb begin
      if (y_in > 0) begin
         x_in_c = x_in + ys;
         y_in_c = y_in - xs;
         z_in_c = z_in + at;
      end else begin
         x_in_c = x_in - ys;
         y_in_c = y_in + xs;
         z_in_c = z_in - at;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in_c;
         y_ff <= y_in_c;
         z_ff <= z_in_c;
         s_ff <= s_in;
      end
   end

   assign v_out = v_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;
   assign s_out = s_ff;

endmodule

// ===== sv/gtg_regs.sv =====
// Configuration register file for the controller's tolerances, gains, limits.
// Depends on gtg_pkg.
module gtg_regs (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [gtg_pkg::IDX_W-1:0] csr_index,
   input  logic [gtg_pkg::CFG_W-1:0] csr_data,
   output logic [gtg_pkg::CFG_W-1:0] dist_tol,
   output logic [gtg_pkg::CFG_W-1:0] ang_tol,
   output logic [gtg_pkg::CFG_W-1:0] lin_gain,
   output logic [gtg_pkg::CFG_W-1:0] ang_gain,
   output logic [gtg_pkg::CFG_W-1:0] lin_max,
   output logic [gtg_pkg::CFG_W-1:0] ang_max,
   output logic [gtg_pkg::CFG_W-1:0] lin_min,
   output logic [gtg_pkg::CFG_W-1:0] ang_min
);

   logic [gtg_pkg::CFG_W-1:0] r_ff [8];

   assign csr_ready = 1'b1;

   // Each write lands in the register its index names.
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff[gtg_pkg::REG_DIST_TOL] <= 24'd3277;
         r_ff[gtg_pkg::REG_ANG_TOL]  <= 24'd66;
         r_ff[gtg_pkg::REG_LIN_GAIN] <= 24'd3277;
         r_ff[gtg_pkg::REG_ANG_GAIN] <= 24'd6554;
         r_ff[gtg_pkg::REG_LIN_MAX]  <= 24'd98304;
         r_ff[gtg_pkg::REG_ANG_MAX]  <= 24'd65536;
         r_ff[gtg_pkg::REG_LIN_MIN]  <= 24'd655;
         r_ff[gtg_pkg::REG_ANG_MIN]  <= 24'd66;
      end else if (csr_valid) begin
         r_ff[csr_index] <= csr_data;
      end
   end

   assign dist_tol = r_ff[gtg_pkg::REG_DIST_TOL];
   assign ang_tol  = r_ff[gtg_pkg::REG_ANG_TOL];
   assign lin_gain = r_ff[gtg_pkg::REG_LIN_GAIN];
   assign ang_gain = r_ff[gtg_pkg::REG_ANG_GAIN];
   assign lin_max  = r_ff[gtg_pkg::REG_LIN_MAX];
   assign ang_max  = r_ff[gtg_pkg::REG_ANG_MAX];
   assign lin_min  = r_ff[gtg_pkg::REG_LIN_MIN];
   assign ang_min  = r_ff[gtg_pkg::REG_ANG_MIN];

endmodule
